FILE: hw/rtl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Types, codes and constants shared by the keypad code lock modules.
// ----------------------------------------------------------------------------
package kcl_pkg;

   localparam int CodeWidth  = 16;
   localparam int TimeWidth  = 32;
   localparam int HoldWidth  = 16;
   localparam int KeyLines   = 12;
   localparam int KeyWidth   = 4;
   localparam int CountWidth = 3;
   localparam int CsrIdxWidth = 2;

   localparam logic [CodeWidth-1:0] INITIAL_CODE_RESET = 16'h1234;
   localparam logic [HoldWidth-1:0] PASS_HOLD_RESET    = 16'd3000;
   localparam logic [HoldWidth-1:0] FAIL_HOLD_RESET    = 16'd1500;
   localparam logic [HoldWidth-1:0] SCAN_PERIOD_RESET  = 16'd100;

   localparam logic [CountWidth-1:0] DIGITS_PER_CODE = 3'd4;

   // key positions in row-major order
   localparam logic [KeyWidth-1:0] KEY_IDX_LAST_DIGIT = 4'd8;
   localparam logic [KeyWidth-1:0] KEY_IDX_STAR       = 4'd9;
   localparam logic [KeyWidth-1:0] KEY_IDX_ZERO       = 4'd10;

   localparam logic [KeyWidth-1:0] KEY_NONE = 4'd0;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_INITIAL_CODE = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PASS_HOLD    = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_FAIL_HOLD    = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_SCAN_PERIOD  = 2'd3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SCAN = 1'b1;

   typedef enum logic [3:0] {
      EV_NONE         = 4'd0,
      EV_DIGIT        = 4'd1,
      EV_CHANGE_START = 4'd2,
      EV_CORRECT      = 4'd3,
      EV_WRONG        = 4'd4,
      EV_ENTER_NEW    = 4'd5,
      EV_REPEAT       = 4'd6,
      EV_CHANGED      = 4'd7,
      EV_MISMATCH     = 4'd8
   } event_type;

   typedef enum logic [3:0] {
      PH_NORMAL  = 4'b0001,
      PH_VERIFY  = 4'b0010,
      PH_NEW     = 4'b0100,
      PH_CONFIRM = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      LED_READY = 3'b001,
      LED_PASS  = 3'b010,
      LED_FAIL  = 3'b100
   } led_type;

   typedef struct packed {
      logic                op;
      logic [KeyLines-1:0] key_lines;
   } req_type;

   typedef struct packed {
      logic [3:0]           event_res;
      logic [CountWidth-1:0] digits_held;
      logic [CodeWidth-1:0] entered_digits;
      logic [1:0]           change_phase;
      logic                 ready_led;
      logic                 pass_led;
      logic                 fail_led;
      logic                 display_clear;
   } rsp_type;

   typedef struct packed {
      logic                found;
      logic [KeyWidth-1:0] code;      // key index plus one
      logic                is_digit;
      logic                is_star;
      logic [3:0]          digit;
   } key_info_type;

   function automatic logic [1:0] phase_code(input phase_type ph);
      logic [1:0] code;
      unique case (ph)
         PH_NORMAL:  code = 2'd0;
         PH_VERIFY:  code = 2'd1;
         PH_NEW:     code = 2'd2;
         PH_CONFIRM: code = 2'd3;
         default:    code = 2'd0;
      endcase
      return code;
   endfunction

endpackage

FILE: hw/rtl/kcl_key_decode.sv
// ----------------------------------------------------------------------------
// kcl_key_decode
// Picks the first pressed key of the 4x3 matrix and classifies it.
// ----------------------------------------------------------------------------
module kcl_key_decode (
   input  logic [kcl_pkg::KeyLines-1:0] key_lines,
   output kcl_pkg::key_info_type        key_info
);
   import kcl_pkg::*;

   logic [KeyWidth-1:0] idx;
   logic                found;

   // lowest set line wins
   always_comb begin
      idx   = '0;
      found = 1'b0;
      for (int i = KeyLines - 1; i >= 0; i--) begin
         if (key_lines[i]) begin
            idx   = KeyWidth'(i);
            found = 1'b1;
         end
      end
   end

   always_comb begin
      key_info.found    = found;
      key_info.code     = found ? idx + 4'd1 : KEY_NONE;
      key_info.is_star  = found && (idx == KEY_IDX_STAR);
      key_info.is_digit = found && ((idx <= KEY_IDX_LAST_DIGIT) || (idx == KEY_IDX_ZERO));
      key_info.digit    = (idx == KEY_IDX_ZERO) ? 4'd0 : idx + 4'd1;
   end

endmodule

FILE: hw/rtl/kcl_core.sv
// ----------------------------------------------------------------------------
// kcl_core
// Lock state, configuration registers and the per-request update.
// ----------------------------------------------------------------------------
module kcl_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [kcl_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [kcl_pkg::CodeWidth-1:0]   csr_wdata,
   input  logic                            item_fire,
   input  kcl_pkg::req_type                item,
   output kcl_pkg::rsp_type                result
);
   import kcl_pkg::*;

   logic [TimeWidth-1:0]  time_count_ff,  time_count_in;
   logic [TimeWidth-1:0]  lock_start_ff,  lock_start_in;
   logic [HoldWidth-1:0]  lock_len_ff,    lock_len_in;
   logic [TimeWidth-1:0]  last_scan_ff,   last_scan_in;
   logic [KeyWidth-1:0]   prev_key_ff,    prev_key_in;
   logic [CountWidth-1:0] digit_count_ff, digit_count_in;
   logic [CodeWidth-1:0]  entry_ff,       entry_in;
   logic [CodeWidth-1:0]  candidate_ff,   candidate_in;
   logic [CodeWidth-1:0]  active_code_ff, active_code_in;
   phase_type             phase_ff,       phase_in;
   led_type               led_ff,         led_in;
   logic [HoldWidth-1:0]  pass_hold_ff,   pass_hold_in;
   logic [HoldWidth-1:0]  fail_hold_ff,   fail_hold_in;
   logic [HoldWidth-1:0]  scan_period_ff, scan_period_in;

   key_info_type          key_info;
   logic [TimeWidth-1:0]  lock_elapsed;
   logic [TimeWidth-1:0]  scan_elapsed;
   logic                  locked;
   logic                  do_lock;
   logic                  lock_pass;
   logic [HoldWidth-1:0]  hold;
   logic [CodeWidth-1:0]  digit_shifted;
   event_type             ev;
   logic                  clr;

   kcl_key_decode u_key_decode (
      .key_lines (item.key_lines),
      .key_info  (key_info)
   );

   assign lock_elapsed = time_count_ff - lock_start_ff;
   assign scan_elapsed = time_count_ff - last_scan_ff;
   assign locked = (lock_len_ff != '0) &&
                   (lock_elapsed < {{(TimeWidth-HoldWidth){1'b0}}, lock_len_ff});

   always_comb begin
      time_count_in  = time_count_ff;
      lock_start_in  = lock_start_ff;
      lock_len_in    = lock_len_ff;
      last_scan_in   = last_scan_ff;
      prev_key_in    = prev_key_ff;
      digit_count_in = digit_count_ff;
      entry_in       = entry_ff;
      candidate_in   = candidate_ff;
      active_code_in = active_code_ff;
      phase_in       = phase_ff;
      led_in         = led_ff;
      pass_hold_in   = pass_hold_ff;
      fail_hold_in   = fail_hold_ff;
      scan_period_in = scan_period_ff;
      ev             = EV_NONE;
      clr            = 1'b0;
      do_lock        = 1'b0;
      lock_pass      = 1'b0;
      digit_shifted  = CodeWidth'({12'd0, key_info.digit} <<
                                  {~digit_count_ff[1:0], 2'b00});

      if (item_fire) begin
         if (item.op == OP_TICK) begin
            time_count_in = time_count_ff + 32'd1;
         end else begin
            // lockout over: entry starts fresh
            if ((lock_len_ff != '0) && !locked) begin
               lock_len_in    = '0;
               digit_count_in = '0;
               entry_in       = '0;
               clr            = 1'b1;
               led_in         = LED_READY;
            end
            if (!locked &&
                (scan_elapsed > {{(TimeWidth-HoldWidth){1'b0}}, scan_period_ff})) begin
               last_scan_in = time_count_ff;
               if (key_info.found && (key_info.code != prev_key_ff)) begin
                  if (key_info.is_star && (digit_count_in == '0) &&
                      (phase_ff == PH_NORMAL)) begin
                     phase_in = PH_VERIFY;
                     ev       = EV_CHANGE_START;
                  end else if (key_info.is_digit && (digit_count_in < DIGITS_PER_CODE)) begin
                     entry_in       = entry_in | digit_shifted;
                     digit_count_in = digit_count_in + 3'd1;
                     ev             = EV_DIGIT;
                     if (digit_count_in == DIGITS_PER_CODE) begin
                        unique case (phase_ff)
                           PH_NORMAL: begin
                              do_lock   = 1'b1;
                              lock_pass = (entry_in == active_code_ff);
                              ev        = lock_pass ? EV_CORRECT : EV_WRONG;
                           end
                           PH_VERIFY: begin
                              if (entry_in == active_code_ff) begin
                                 phase_in       = PH_NEW;
                                 digit_count_in = '0;
                                 entry_in       = '0;
                                 clr            = 1'b1;
                                 ev             = EV_ENTER_NEW;
                              end else begin
                                 phase_in = PH_NORMAL;
                                 do_lock  = 1'b1;
                                 ev       = EV_WRONG;
                              end
                           end
                           PH_NEW: begin
                              candidate_in   = entry_in;
                              phase_in       = PH_CONFIRM;
                              digit_count_in = '0;
                              entry_in       = '0;
                              clr            = 1'b1;
                              ev             = EV_REPEAT;
                           end
                           PH_CONFIRM: begin
                              phase_in  = PH_NORMAL;
                              do_lock   = 1'b1;
                              lock_pass = (entry_in == candidate_ff);
                              if (lock_pass) begin
                                 active_code_in = candidate_ff;
                                 ev             = EV_CHANGED;
                              end else begin
                                 ev = EV_MISMATCH;
                              end
                           end
                           default: begin
                              phase_in = PH_NORMAL;
                           end
                        endcase
                     end
                  end
                  prev_key_in = key_info.code;
               end else if (!key_info.found) begin
                  prev_key_in = KEY_NONE;
               end
            end
         end
      end

      hold = lock_pass ? pass_hold_ff : fail_hold_ff;
      if (do_lock) begin
         lock_start_in = time_count_ff;
         lock_len_in   = (hold == '0) ? 16'd1 : hold;
         led_in        = lock_pass ? LED_PASS : LED_FAIL;
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_INITIAL_CODE: active_code_in = csr_wdata;
            CSR_PASS_HOLD:    pass_hold_in   = csr_wdata;
            CSR_FAIL_HOLD:    fail_hold_in   = csr_wdata;
            CSR_SCAN_PERIOD:  scan_period_in = csr_wdata;
            default:          active_code_in = active_code_ff;
         endcase
      end
   end

   always_comb begin
      result.event_res      = ev;
      result.digits_held    = digit_count_in;
      result.entered_digits = entry_in;
      result.change_phase   = phase_code(phase_in);
      result.ready_led      = led_in[0];
      result.pass_led       = led_in[1];
      result.fail_led       = led_in[2];
      result.display_clear  = clr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_count_ff  <= '0;
         lock_start_ff  <= '0;
         lock_len_ff    <= '0;
         last_scan_ff   <= '0;
         prev_key_ff    <= KEY_NONE;
         digit_count_ff <= '0;
         entry_ff       <= '0;
         candidate_ff   <= '0;
         active_code_ff <= INITIAL_CODE_RESET;
         phase_ff       <= PH_NORMAL;
         led_ff         <= LED_READY;
         pass_hold_ff   <= PASS_HOLD_RESET;
         fail_hold_ff   <= FAIL_HOLD_RESET;
         scan_period_ff <= SCAN_PERIOD_RESET;
      end else begin
         time_count_ff  <= time_count_in;
         lock_start_ff  <= lock_start_in;
         lock_len_ff    <= lock_len_in;
         last_scan_ff   <= last_scan_in;
         prev_key_ff    <= prev_key_in;
         digit_count_ff <= digit_count_in;
         entry_ff       <= entry_in;
         candidate_ff   <= candidate_in;
         active_code_ff <= active_code_in;
         phase_ff       <= phase_in;
         led_ff         <= led_in;
         pass_hold_ff   <= pass_hold_in;
         fail_hold_ff   <= fail_hold_in;
         scan_period_ff <= scan_period_in;
      end
   end

endmodule

FILE: hw/rtl/keypad_code_lock.sv
// ----------------------------------------------------------------------------
// keypad_code_lock
// Four-digit keypad code lock with code change, LEDs and lockout timing.
// ----------------------------------------------------------------------------
// Every request (a time tick or a keypad scan) gives exactly one response.
// Requests land in an input register and are resolved combinationally by
// the lock state update into a result register, so one request per cycle is
// sustained while rsp_stall is low, and a response is offered from there.
// An empty input register accepts while a response waits on rsp_stall;
// req_stall rises only when both registers are full and the output is held.
// Configuration writes take effect at once; a write of the initial code also
// replaces the active code.
module keypad_code_lock (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  kcl_pkg::req_type                req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output kcl_pkg::rsp_type                rsp_item,
   input  logic                            csr_we,
   input  logic [kcl_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [kcl_pkg::CodeWidth-1:0]   csr_wdata
);
   import kcl_pkg::*;

   logic    req_valid_ff, req_valid_in;
   req_type req_item_ff,  req_item_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff,  rsp_item_in;
   rsp_type result;
   logic    advance;

   // request moves to the result register when that one is free or draining
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   kcl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .item_fire (advance),
      .item      (req_item_ff),
      .result    (result)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      req_item_in  = req_item_ff;
      if (!req_stall) begin
         req_valid_in = req_valid;
         req_item_in  = req_item;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_item_ff <= req_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
